// File: design/assert_macros.svh
// Assertion macros used by the semaphore unit.
// SU_ASSERT checks a property on every rising clock edge outside reset.
// SU_ASSERT_IMP checks that a consequent holds whenever its antecedent holds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define SU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define SU_ASSERT(lbl, clk, rst, prop, msg)

`define SU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: design/sem_wq_pkg.sv
package sem_wq_pkg;

   // Default sizes of the semaphore bank.
   localparam int unsigned DEF_NUM_SEMAPHORES = 128;
   localparam int unsigned DEF_QUEUE_SLOTS    = 16;

   // Field widths.
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned SEM_ID_W = 7;
   localparam int unsigned REQ_ID_W = 6;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned STATUS_W = 2;

   // Stream widths.
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned REQ_TUSER_W = ACTION_W;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned RSP_TUSER_W = STATUS_W + 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CREATE = 2'd0,
      ACT_DOWN   = 2'd1,
      ACT_UP     = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BLOCKED = 2'd1,
      STATUS_QFULL   = 2'd2,
      STATUS_NOFREE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FETCH
   } state_type;

endpackage

// File: design/semaphore_unit_with_wait_fifo_top.sv
// Bank of counting semaphores, each with a circular wait queue of blocked requesters.
// Requests arrive on the req_ stream: the action (create, down, up) travels in req_tuser,
// the semaphore id, requester id and initial count in req_tdata. Every request produces
// exactly one transfer on the rsp_ stream: status and woken flag in rsp_tuser, the woken
// requester id and the newly assigned semaphore id in rsp_tdata.
// Counts and queue pointers live in one synchronous memory with one entry per semaphore;
// queued requester ids live in a second memory with QUEUE_SLOTS entries per semaphore.
// Each request does a read-modify-write of its semaphore entry, one request at a time.
// A create, a down and an up that finds an empty queue go from the lookup state straight to
// the output register; an up that wakes a waiter passes through a fetch state first, since
// its id takes an extra read of the wait-queue memory.
// So a new request waits until the last is done, paced by the entry memory read followed
// by its write-back and, for a wake, by the dependent read of the queue memory.
// After reset the block sweeps the entry memory, one semaphore per cycle, over all
// NUM_SEMAPHORES entries; req_tready stays low during that sweep.
// The result sits in an output register. A new request is accepted while a result waits;
// if the receiver stalls, the following request waits in its final step until the output
// register frees up, and req_tready stays low until then.
`include "assert_macros.svh"

module semaphore_unit_with_wait_fifo_top #(
   parameter int unsigned NUM_SEMAPHORES = sem_wq_pkg::DEF_NUM_SEMAPHORES,
   parameter int unsigned QUEUE_SLOTS    = sem_wq_pkg::DEF_QUEUE_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sem_id [6:0], requester_id [12:7], init_value [28:13], zero [31:29]
   input  logic [sem_wq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action [1:0]
   input  logic [sem_wq_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // woken_id [5:0], new_sem_id [12:6], zero [15:13]
   output logic [sem_wq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // status [1:0], woken_valid [2]
   output logic [sem_wq_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import sem_wq_pkg::*;

   localparam int unsigned SEM_AW = $clog2(NUM_SEMAPHORES);
   localparam int unsigned PW     = $clog2(QUEUE_SLOTS);
   localparam int unsigned NFW    = $clog2(NUM_SEMAPHORES + 1);
   localparam int unsigned WAW    = SEM_AW + PW;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [PW-1:0]      head;
      logic [PW-1:0]      tail;
   } entry_type;

   // Control state.
   state_type           state_ff, state_in;
   logic [SEM_AW-1:0]   clr_ff, clr_in;
   logic [NFW-1:0]      nfid_ff, nfid_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // Captured request.
   logic [ACTION_W-1:0] item_action_ff;
   logic [SEM_ID_W-1:0] item_sem_id_ff;
   logic [REQ_ID_W-1:0] item_req_ff;
   logic [COUNT_W-1:0]  item_init_ff;

   // Result register.
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_wvalid_ff;
   logic [REQ_ID_W-1:0] rsp_wid_ff;
   logic [SEM_ID_W-1:0] rsp_newid_ff;

   // Memories.
   entry_type           entry_mem [NUM_SEMAPHORES];
   entry_type           entry_rd_ff;
   logic [REQ_ID_W-1:0] wait_mem [1 << WAW];
   logic [REQ_ID_W-1:0] wait_rd_ff;

   // Request field extraction.
   logic [SEM_ID_W-1:0]        req_sem_id;
   logic [REQ_ID_W-1:0]        req_requester_id;
   logic [COUNT_W-1:0]         req_init_value;
   logic [SEM_AW+SEM_ID_W-1:0] req_sid_ext;
   logic [SEM_AW+SEM_ID_W-1:0] item_sid_ext;
   logic [NFW+SEM_ID_W-1:0]    nfid_ext;
   logic [SEM_AW-1:0]          req_idx;
   logic [SEM_AW-1:0]          item_idx;
   logic                       item_in_range;
   logic                       accept;
   logic                       out_free;

   // Memory port controls and result values.
   logic                entry_we;
   logic [SEM_AW-1:0]   entry_waddr;
   entry_type           entry_wdata;
   logic                wait_we;
   logic                wait_re;
   logic [PW-1:0]       next_head;
   logic [PW-1:0]       next_tail;
   logic                out_load;
   status_type          res_status;
   logic                res_wvalid;
   logic [REQ_ID_W-1:0] res_wid;
   logic [SEM_ID_W-1:0] res_newid;

   assign req_sem_id       = req_tdata[6:0];
   assign req_requester_id = req_tdata[12:7];
   assign req_init_value   = req_tdata[28:13];

   assign req_sid_ext   = (SEM_AW + SEM_ID_W)'(req_sem_id);
   assign req_idx       = req_sid_ext[SEM_AW-1:0];
   assign item_sid_ext  = (SEM_AW + SEM_ID_W)'(item_sem_id_ff);
   assign item_idx      = item_sid_ext[SEM_AW-1:0];
   assign item_in_range = 32'(item_sem_id_ff) < NUM_SEMAPHORES;
   assign nfid_ext      = (NFW + SEM_ID_W)'(nfid_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Pointer advance with wrap at the end of the ring.
   assign next_head = (entry_rd_ff.head == PW'(QUEUE_SLOTS - 1)) ? '0 : entry_rd_ff.head + 1'b1;
   assign next_tail = (entry_rd_ff.tail == PW'(QUEUE_SLOTS - 1)) ? '0 : entry_rd_ff.tail + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         nfid_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         nfid_ff       <= nfid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_action_ff <= req_tuser;
         item_sem_id_ff <= req_sem_id;
         item_req_ff    <= req_requester_id;
         item_init_ff   <= req_init_value;
      end
      if (out_load) begin
         rsp_status_ff <= res_status;
         rsp_wvalid_ff <= res_wvalid;
         rsp_wid_ff    <= res_wid;
         rsp_newid_ff  <= res_newid;
      end
   end

   // Semaphore entry memory: the read is issued as the request is accepted.
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_waddr] <= entry_wdata;
      end
      if (accept) begin
         entry_rd_ff <= entry_mem[req_idx];
      end
   end

   // Wait-queue memory: the slot address is the semaphore index above the ring pointer.
   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[{item_idx, entry_rd_ff.tail}] <= item_req_ff;
      end
      if (wait_re) begin
         wait_rd_ff <= wait_mem[{item_idx, entry_rd_ff.head}];
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      nfid_in     = nfid_ff;
      entry_we    = 1'b0;
      entry_waddr = item_idx;
      entry_wdata = entry_rd_ff;
      wait_we     = 1'b0;
      wait_re     = 1'b0;
      out_load    = 1'b0;
      res_status  = STATUS_OK;
      res_wvalid  = 1'b0;
      res_wid     = '0;
      res_newid   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            entry_we    = 1'b1;
            entry_waddr = clr_ff;
            entry_wdata = '0;
            if (clr_ff == SEM_AW'(NUM_SEMAPHORES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (item_action_ff == ACT_UP && item_in_range &&
                entry_rd_ff.head != entry_rd_ff.tail) begin
               // A waiter is released: pop the head, the count stays as it is.
               wait_re          = 1'b1;
               entry_we         = 1'b1;
               entry_wdata.head = next_head;
               state_in         = ST_FETCH;
            end else if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               unique case (item_action_ff)
                  ACT_CREATE: begin
                     if (nfid_ff == NFW'(NUM_SEMAPHORES)) begin
                        res_status = STATUS_NOFREE;
                     end else begin
                        entry_we          = 1'b1;
                        entry_waddr       = nfid_ff[SEM_AW-1:0];
                        entry_wdata.count = item_init_ff;
                        entry_wdata.head  = '0;
                        entry_wdata.tail  = '0;
                        res_newid         = nfid_ext[SEM_ID_W-1:0];
                        nfid_in           = nfid_ff + 1'b1;
                     end
                  end
                  ACT_DOWN: begin
                     if (item_in_range) begin
                        priority if (entry_rd_ff.count != '0) begin
                           entry_we          = 1'b1;
                           entry_wdata.count = entry_rd_ff.count - 1'b1;
                        end else if (next_tail == entry_rd_ff.head) begin
                           res_status = STATUS_QFULL;
                        end else begin
                           wait_we          = 1'b1;
                           entry_we         = 1'b1;
                           entry_wdata.tail = next_tail;
                           res_status       = STATUS_BLOCKED;
                        end
                     end
                  end
                  ACT_UP: begin
                     // Empty queue here; the count saturates at its maximum.
                     if (item_in_range && entry_rd_ff.count != COUNT_MAX) begin
                        entry_we          = 1'b1;
                        entry_wdata.count = entry_rd_ff.count + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            if (out_free) begin
               out_load   = 1'b1;
               res_wvalid = 1'b1;
               res_wid    = wait_rd_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      rsp_tvalid_in = out_load || (rsp_tvalid_ff && !rsp_tready);
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = {rsp_wvalid_ff, rsp_status_ff};
   assign rsp_tdata  = {3'b000, rsp_newid_ff, rsp_wid_ff};

   // Only one request is in flight: an accepted transfer closes the input at once.
   `SU_ASSERT_IMP(a_one_in_flight, clock, reset, accept, ##1 !req_tready, "second request accepted while one is in flight")
   // The id pool pointer never runs past the bank size.
   `SU_ASSERT(a_nfid_bound, clock, reset, nfid_ff <= NFW'(NUM_SEMAPHORES), "next free id beyond bank size")
   // A wake result is always a plain success and never carries a created id.
   `SU_ASSERT_IMP(a_wake_ok, clock, reset, rsp_tvalid_ff && rsp_wvalid_ff, rsp_status_ff == STATUS_OK && rsp_newid_ff == '0, "wake result with bad status or id")
   // Queue pointers read back from the entry memory stay inside the ring.
   `SU_ASSERT_IMP(a_ptr_range, clock, reset, state_ff == ST_LOOKUP && item_in_range, entry_rd_ff.head <= PW'(QUEUE_SLOTS - 1) && entry_rd_ff.tail <= PW'(QUEUE_SLOTS - 1), "queue pointer outside ring")

endmodule

// File: tb/sv/tb_semaphore_unit_with_wait_fifo_top.sv
module tb_semaphore_unit_with_wait_fifo_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sem_wq_pkg::*;

   // Sizes match the defaults the block is built with.
   localparam int unsigned NUM_SEM = DEF_NUM_SEMAPHORES;
   localparam int unsigned SLOTS   = DEF_QUEUE_SLOTS;
   localparam int unsigned PTR_W   = $clog2(DEF_QUEUE_SLOTS);

   // The action code the block must ignore.
   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

   // Random requests per idling phase; three phases give about 450 requests.
   localparam int unsigned PHASE_ITEMS = 150;
   localparam int unsigned NUM_PHASES  = 3;

   // A wake passes through the lookup and fetch states to the output register, so a
   // short quiet window at the end is enough to catch any stray result.
   localparam int unsigned QUIET_CYCLES = 20;

   // The slowest correct run is the clearing sweep plus roughly 480 requests,
   // each waiting out a long sender gap, a long receiver stall and its own
   // work in the block. This limit is many times that.
   localparam int unsigned CYCLE_LIMIT = 200_000;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [SEM_ID_W-1:0] sem_id;
      logic [REQ_ID_W-1:0] requester;
      logic [COUNT_W-1:0]  init_count;
   } sem_request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                woken_valid;
      logic [REQ_ID_W-1:0] woken_id;
      logic [SEM_ID_W-1:0] new_sem_id;
   } sem_response_type;

   // One line of the directed table. A line may be issued several times in a
   // row, with the requester id counting up from the given one. Where typed is
   // set, the answer below is the expected result; otherwise the predictor's.
   typedef struct {
      sem_request_type  req;
      int unsigned      copies;
      bit               typed;
      sem_response_type rsp;
   } directed_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // sem_id [6:0], requester_id [12:7], init_value [28:13], zero [31:29]
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // action [1:0]
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // woken_id [5:0], new_sem_id [12:6], zero [15:13]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // status [1:0], woken_valid [2]
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   semaphore_unit_with_wait_fifo_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the semaphore bank: counts, queue read and write pointers, the
   // queued requester ids and the next id that a create hands out.
   logic [COUNT_W-1:0]  sem_level [NUM_SEM];
   logic [PTR_W-1:0]    wq_rd_ptr [NUM_SEM];
   logic [PTR_W-1:0]    wq_wr_ptr [NUM_SEM];
   logic [REQ_ID_W-1:0] wq_slot   [NUM_SEM*SLOTS];
   int unsigned         ids_issued;

   // Results still owed by the block, oldest first.
   sem_response_type owed_results[$];

   // Idling percentages of the current phase, one for each side.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   int unsigned mismatches    = 0;
   int unsigned requests_sent = 0;
   int unsigned results_seen  = 0;
   int unsigned blocked_seen  = 0;
   int unsigned wakes_seen    = 0;
   int unsigned qfull_seen    = 0;
   int unsigned nofree_seen   = 0;
   int unsigned cycles        = 0;

   // Applies one accepted request to the mirrored bank and returns the result
   // the block must give for it.
   function automatic sem_response_type apply_request(input sem_request_type rq);
      sem_response_type r;
      int unsigned      s;
      logic [PTR_W-1:0] rd;
      logic [PTR_W-1:0] wr;
      logic [PTR_W-1:0] wr_next;
      r.status      = STATUS_OK;
      r.woken_valid = 1'b0;
      r.woken_id    = '0;
      r.new_sem_id  = '0;
      s       = rq.sem_id;
      rd      = wq_rd_ptr[s];
      wr      = wq_wr_ptr[s];
      wr_next = wr + 1'b1;
      case (rq.action)
         ACT_CREATE: begin
            // Ids are handed out once each; when the pool is used up the
            // create changes nothing.
            if (ids_issued >= NUM_SEM) begin
               r.status = STATUS_NOFREE;
            end else begin
               sem_level[ids_issued] = rq.init_count;
               wq_rd_ptr[ids_issued] = '0;
               wq_wr_ptr[ids_issued] = '0;
               r.new_sem_id          = ids_issued[SEM_ID_W-1:0];
               ids_issued++;
            end
         end
         ACT_DOWN: begin
            // A zero count queues the requester, unless one more entry would
            // make the write pointer catch up with the read pointer.
            if (sem_level[s] != '0) begin
               sem_level[s] = sem_level[s] - 1'b1;
            end else if (wr_next == rd) begin
               r.status = STATUS_QFULL;
            end else begin
               wq_slot[s*SLOTS + wr] = rq.requester;
               wq_wr_ptr[s]          = wr_next;
               r.status              = STATUS_BLOCKED;
            end
         end
         ACT_UP: begin
            // A waiter takes the permit directly; only with nobody waiting
            // does the count go up, and it stops at its maximum.
            if (rd != wr) begin
               r.woken_valid = 1'b1;
               r.woken_id    = wq_slot[s*SLOTS + rd];
               wq_rd_ptr[s]  = rd + 1'b1;
            end else if (sem_level[s] != COUNT_MAX) begin
               sem_level[s] = sem_level[s] + 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic directed_row_type row(input logic [ACTION_W-1:0] action,
                                            input int unsigned sid, input int unsigned rq,
                                            input int unsigned init,
                                            input int unsigned copies,
                                            input int unsigned typed,
                                            input logic [STATUS_W-1:0] status,
                                            input int unsigned wv, input int unsigned wid,
                                            input int unsigned nid);
      directed_row_type d;
      d.req.action      = action;
      d.req.sem_id      = sid[SEM_ID_W-1:0];
      d.req.requester   = rq[REQ_ID_W-1:0];
      d.req.init_count  = init[COUNT_W-1:0];
      d.copies          = copies;
      d.typed           = typed[0];
      d.rsp.status      = status;
      d.rsp.woken_valid = wv[0];
      d.rsp.woken_id    = wid[REQ_ID_W-1:0];
      d.rsp.new_sem_id  = nid[SEM_ID_W-1:0];
      return d;
   endfunction

   // Presents one request, waits for its transfer and records what it owes.
   // The sender may idle first; the valid stays high from one request to the
   // next when it does not.
   task automatic offer_request(input sem_request_type rq, input bit typed,
                                input sem_response_type typed_rsp);
      sem_response_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.action;
      req_tdata  <= {3'b000, rq.init_count, rq.requester, rq.sem_id};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = apply_request(rq);
      owed_results.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
   endtask

   // Holds the sender back until every owed result has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (owed_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: result %0d, %s expected 0x%0h, got 0x%0h",
                  $time, results_seen, name, want, got);
         mismatches++;
      end
   endfunction

   // Result side: the ready is redrawn every cycle from the phase's stall
   // rate, and each transfer is compared with the oldest owed result. Outputs
   // are read right after the edge, so they hold the values the edge saw.
   initial begin
      sem_response_type want;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: result with nothing owed, tuser 0x%0h tdata 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               compare_field("status", want.status, rsp_tuser[STATUS_W-1:0]);
               compare_field("woken_valid", want.woken_valid, rsp_tuser[STATUS_W]);
               compare_field("woken_id", want.woken_id, rsp_tdata[REQ_ID_W-1:0]);
               compare_field("new_sem_id", want.new_sem_id,
                             rsp_tdata[REQ_ID_W +: SEM_ID_W]);
            end
            results_seen++;
            case (rsp_tuser[STATUS_W-1:0])
               STATUS_BLOCKED: blocked_seen++;
               STATUS_QFULL:   qfull_seen++;
               STATUS_NOFREE:  nofree_seen++;
               default: begin
               end
            endcase
            if (rsp_tuser[STATUS_W]) begin
               wakes_seen++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results still owed",
                  cycles, owed_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      directed_row_type steps[$];
      sem_request_type  rq;
      sem_response_type none;
      int unsigned      down_pct [NUM_PHASES];
      int unsigned      send_pct [NUM_PHASES];
      int unsigned      recv_pct [NUM_PHASES];
      int unsigned      roll;
      int unsigned      back;
      int unsigned      sid;
      int unsigned      pick;

      down_pct = '{40, 21, 31};
      send_pct = '{18, 60, 0};
      recv_pct = '{60, 18, 0};
      for (int unsigned i = 0; i < NUM_SEM; i++) begin
         sem_level[i] = '0;
         wq_rd_ptr[i] = '0;
         wq_wr_ptr[i] = '0;
      end
      ids_issued       = 0;
      none.status      = STATUS_OK;
      none.woken_valid = 1'b0;
      none.woken_id    = '0;
      none.new_sem_id  = '0;
      send_idle_pct    = send_pct[0];
      recv_idle_pct    = recv_pct[0];

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block is fresh out of reset, so most answers can
      // be written down directly: a semaphore never created starts at a zero
      // count with an empty queue, ids come out in order from zero, the count
      // stays at its maximum, and the unused action code answers all zeros.
      // The run of downs on the top semaphore fills its queue, and the
      // following down must be refused.
      steps.push_back(row(ACT_DOWN,    5, 21,     0,  1, 1, STATUS_BLOCKED, 0,  0, 0));
      steps.push_back(row(ACT_UP,      5,  0,     0,  1, 1, STATUS_OK,      1, 21, 0));
      steps.push_back(row(ACT_CREATE,  0,  0,     0,  1, 1, STATUS_OK,      0,  0, 0));
      steps.push_back(row(ACT_CREATE, 96,  7, 65535,  1, 1, STATUS_OK,      0,  0, 1));
      steps.push_back(row(ACT_UP,      1,  0,     0,  1, 1, STATUS_OK,      0,  0, 0));
      steps.push_back(row(ACT_CREATE,  0,  0,     1,  1, 1, STATUS_OK,      0,  0, 2));
      steps.push_back(row(ACT_DOWN,    2, 63,     0,  1, 1, STATUS_OK,      0,  0, 0));
      steps.push_back(row(ACT_DOWN,    2, 42,     0,  1, 1, STATUS_BLOCKED, 0,  0, 0));
      steps.push_back(row(ACT_UP,      2,  0,     0,  1, 1, STATUS_OK,      1, 42, 0));
      steps.push_back(row(ACT_RESERVED, 127, 63, 65535, 1, 1, STATUS_OK,    0,  0, 0));
      steps.push_back(row(ACT_DOWN,  127,  0,     0, SLOTS - 1, 0, STATUS_OK, 0, 0, 0));
      steps.push_back(row(ACT_DOWN,  127, 63,     0,  1, 1, STATUS_QFULL,   0,  0, 0));

      foreach (steps[i]) begin
         for (int unsigned c = 0; c < steps[i].copies; c++) begin
            rq           = steps[i].req;
            rq.requester = rq.requester + c[REQ_ID_W-1:0];
            offer_request(rq, steps[i].typed, steps[i].rsp);
         end
      end
      drain_results();

      // Random part, in three phases of idling. The first leans on downs so
      // that the hot semaphores pile up waiters toward a full queue, the
      // second leans on ups to wake them all again, the third is balanced
      // with neither side idling. About a third of the requests are creates,
      // so the id pool runs dry along the way. Each phase ends with the
      // sender holding off until every owed result has come out.
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct = send_pct[p];
         recv_idle_pct = recv_pct[p];
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
               rq.action = ACT_CREATE;
            end else if (roll < 35 + down_pct[p]) begin
               rq.action = ACT_DOWN;
            end else if (roll < 96) begin
               rq.action = ACT_UP;
            end else begin
               rq.action = ACT_RESERVED;
            end

            // Half the traffic goes to a few hot semaphores so their queues
            // fill and wrap; much of the rest goes to the newest ids.
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               case ($urandom_range(0, 3))
                  0:       sid = 0;
                  1:       sid = 2;
                  2:       sid = 5;
                  default: sid = NUM_SEM - 1;
               endcase
            end else if (pick < 80 && ids_issued > 0) begin
               back = $urandom_range(0, (ids_issued > 4) ? 3 : ids_issued - 1);
               sid  = ids_issued - 1 - back;
            end else begin
               sid = $urandom_range(0, NUM_SEM - 1);
            end
            rq.sem_id    = sid[SEM_ID_W-1:0];
            rq.requester = REQ_ID_W'($urandom_range(0, (1 << REQ_ID_W) - 1));

            // Small initial counts keep downs blocking; the rest spreads over
            // the full range and the top of it.
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rq.init_count = COUNT_W'($urandom_range(0, 2));
            end else if (pick < 85) begin
               rq.init_count = COUNT_W'($urandom_range(0, 65535));
            end else begin
               rq.init_count = COUNT_MAX - COUNT_W'($urandom_range(0, 1));
            end

            offer_request(rq, 1'b0, none);
         end
         drain_results();
      end

      repeat (QUIET_CYCLES) @(posedge clock);

      $display("Ran %0d requests and checked %0d results under three idling mixes.",
               requests_sent, results_seen);
      $display("Saw %0d blocked downs, %0d wake-ups, %0d full-queue refusals, %0d refused creates.",
               blocked_seen, wakes_seen, qfull_seen, nofree_seen);
      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
